// ----- design/ssbg_pkg.sv -----
package ssbg_pkg;

  // Field widths of the beats.
  localparam int SAMPLE_BITS = 24;
  localparam int IDX_W       = 9;
  localparam int RED_W       = 10;

  // Default profile depth.
  localparam int NUM_BINS_DEF = 512;

  // Magnitude square root.
  localparam int SQ_W      = 2 * SAMPLE_BITS;
  localparam int ROOT_W    = SAMPLE_BITS;
  localparam int REM_W     = SAMPLE_BITS + 2;
  localparam int SQ_STAGES = 6;
  localparam int SQ_ITERS  = ROOT_W / SQ_STAGES;

  // Gain arithmetic, unsigned Q1.16.
  localparam int GAIN_W     = 17;
  localparam int QUOT_W     = 16;
  localparam int OVER_SUB   = 3;
  localparam int RED_FULL   = 1000;
  localparam int RED3_W     = RED_W + 2;
  localparam int NUM_W      = RED3_W + SAMPLE_BITS;
  localparam int DEN_W      = SAMPLE_BITS + 10;
  localparam int DIV_STAGES = 4;
  localparam int DIV_ITERS  = QUOT_W / DIV_STAGES;
  localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_FLOOR = 17'd1311;

  // Scaling product and rounding.
  localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;

  // Configuration registers.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RED_W;
  localparam logic [CFG_IDX_W-1:0] REG_REDUCTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_MODE = 2'd1;
  localparam logic [RED_W-1:0]     RED_RESET     = 10'd500;

  typedef struct packed {
    logic                          action;
    logic [IDX_W-1:0]              bin_index;
    logic signed [SAMPLE_BITS-1:0] bin_real;
    logic signed [SAMPLE_BITS-1:0] bin_imag;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]              out_index;
    logic signed [SAMPLE_BITS-1:0] out_real;
    logic signed [SAMPLE_BITS-1:0] out_imag;
  } out_beat_t;

  typedef struct packed {
    logic [RED_W-1:0] reduction;
    logic             diff_mode;
  } cfg_t;

  typedef struct packed {
    in_beat_t          bin;
    logic [ROOT_W-1:0] mag;
  } mag_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]              bin_index;
    logic signed [SAMPLE_BITS-1:0] bin_real;
    logic signed [SAMPLE_BITS-1:0] bin_imag;
    logic                          pass;
    logic                          mag_zero;
    logic                          clamp;
    logic [QUOT_W-1:0]             quot;
  } gain_beat_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic             qbit;
  } div_t;

  // One step of the restoring square root: brings in two radicand bits.
  function automatic sq_t sq_step(input logic [REM_W-1:0] rem, input logic [ROOT_W-1:0] root,
                                  input logic [1:0] pair);
    logic [REM_W+1:0] r2;
    logic [REM_W+1:0] trial;
    sq_t              res;
    r2    = {rem, pair};
    trial = (REM_W + 2)'({root, 2'b01});
    if (r2 >= trial) begin
      res.rem  = REM_W'(r2 - trial);
      res.root = {root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = REM_W'(r2);
      res.root = {root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

  // One step of the restoring divider; the remainder stays below the divisor.
  function automatic div_t div_step(input logic [DEN_W-1:0] rem, input logic [DEN_W-1:0] den);
    logic [DEN_W:0] r2;
    div_t           res;
    r2 = {rem, 1'b0};
    if (r2 >= {1'b0, den}) begin
      res.rem  = DEN_W'(r2 - {1'b0, den});
      res.qbit = 1'b1;
    end else begin
      res.rem  = DEN_W'(r2);
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

// ----- design/ssbg_ram.sv -----
module ssbg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ssbg_mag.sv -----
module ssbg_mag import ssbg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mag_beat_t out_data_o
);

  localparam int NS = SQ_STAGES;

  logic                  a_v_q, b_v_q;
  in_beat_t              a_bin_q, b_bin_q;
  logic [SQ_W-2:0]       a_sqr_q, a_sqi_q;
  logic [SQ_W-1:0]       b_rad_q;
  logic signed [SQ_W-1:0] sqr_full, sqi_full;
  logic                  a_rdy, b_rdy;

  logic                  c_v_q    [NS];
  in_beat_t              c_bin_q  [NS];
  logic [SQ_W-1:0]       c_rad_q  [NS];
  logic [REM_W-1:0]      c_rem_q  [NS];
  logic [ROOT_W-1:0]     c_root_q [NS];
  logic [SQ_W-1:0]       c_rad_d  [NS];
  logic [REM_W-1:0]      c_rem_d  [NS];
  logic [ROOT_W-1:0]     c_root_d [NS];
  logic                  c_rdy    [NS];

  // Squares of both parts; they are never negative.
  assign sqr_full = in_data_i.bin_real * in_data_i.bin_real;
  assign sqi_full = in_data_i.bin_imag * in_data_i.bin_imag;

  // Ready runs back from the output through every stage.
  always_comb begin
    for (int k = NS - 1; k >= 0; k--) begin
      if (k == NS - 1) begin
        c_rdy[k] = !c_v_q[k] || out_ready_i;
      end else begin
        c_rdy[k] = !c_v_q[k] || c_rdy[k+1];
      end
    end
  end

  assign b_rdy      = !b_v_q || c_rdy[0];
  assign a_rdy      = !a_v_q || b_rdy;
  assign in_ready_o = a_rdy;

  // Square root stages, four radicand bit pairs each.
  always_comb begin
    sq_t              st;
    logic [SQ_W-1:0]  rad;
    logic [REM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        rad  = b_rad_q;
        rem  = '0;
        root = '0;
      end else begin
        rad  = c_rad_q[k-1];
        rem  = c_rem_q[k-1];
        root = c_root_q[k-1];
      end
      for (int i = 0; i < SQ_ITERS; i++) begin
        st   = sq_step(rem, root, rad[SQ_W-1 -: 2]);
        rem  = st.rem;
        root = st.root;
        rad  = {rad[SQ_W-3:0], 2'b00};
      end
      c_rad_d[k]  = rad;
      c_rem_d[k]  = rem;
      c_root_d[k] = root;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      for (int k = 0; k < NS; k++) begin
        c_v_q[k] <= 1'b0;
      end
    end else begin
      if (a_rdy) begin
        a_v_q <= in_valid_i;
      end
      if (b_rdy) begin
        b_v_q <= a_v_q;
      end
      for (int k = 0; k < NS; k++) begin
        if (c_rdy[k]) begin
          c_v_q[k] <= (k == 0) ? b_v_q : c_v_q[k-1];
        end
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      a_bin_q <= in_data_i;
      a_sqr_q <= sqr_full[SQ_W-2:0];
      a_sqi_q <= sqi_full[SQ_W-2:0];
    end
    if (b_rdy) begin
      b_bin_q <= a_bin_q;
      b_rad_q <= {1'b0, a_sqr_q} + {1'b0, a_sqi_q};
    end
    for (int k = 0; k < NS; k++) begin
      if (c_rdy[k]) begin
        c_bin_q[k]  <= (k == 0) ? b_bin_q : c_bin_q[k-1];
        c_rad_q[k]  <= c_rad_d[k];
        c_rem_q[k]  <= c_rem_d[k];
        c_root_q[k] <= c_root_d[k];
      end
    end
  end

  assign out_valid_o    = c_v_q[NS-1];
  assign out_data_o.bin = c_bin_q[NS-1];
  assign out_data_o.mag = c_root_q[NS-1];

endmodule

// ----- design/ssbg_gain.sv -----
module ssbg_gain import ssbg_pkg::*; #(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  output logic       busy_o,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  mag_beat_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output gain_beat_t out_data_o
);

  localparam int AW = $clog2(NUM_BINS);
  localparam int ND = DIV_STAGES;

  // Clearing sweep of the profile after reset.
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  // Profile stage.
  logic              g1_v_q, g1_lrn_q, g1_rdy, ld_g1;
  in_beat_t          g1_bin_q;
  logic [ROOT_W-1:0] g1_mag_q;
  logic [IDX_W-1:0]  slot_r;
  logic [AW-1:0]     slot;
  logic              learned_q;
  logic [ROOT_W-1:0] ram_rdata, prof;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ROOT_W-1:0] ram_wdata;

  // Products stage.
  logic              g2_v_q, g2_pass_q, g2_magz_q, g2_rdy;
  in_beat_t          g2_bin_q;
  logic [NUM_W-1:0]  g2_num_q, num_d;
  logic [DEN_W-1:0]  g2_den_q, den_d;
  logic [RED3_W-1:0] red3;

  // Clamp stage.
  logic             g3_v_q, g3_pass_q, g3_magz_q, g3_clamp_q, g3_rdy;
  in_beat_t         g3_bin_q;
  logic [DEN_W-1:0] g3_den_q, g3_rem_q;

  // Divider stages.
  logic              d_v_q     [ND];
  in_beat_t          d_bin_q   [ND];
  logic              d_pass_q  [ND];
  logic              d_magz_q  [ND];
  logic              d_clamp_q [ND];
  logic [DEN_W-1:0]  d_den_q   [ND];
  logic [DEN_W-1:0]  d_rem_q   [ND];
  logic [QUOT_W-1:0] d_quot_q  [ND];
  logic [DEN_W-1:0]  d_rem_d   [ND];
  logic [QUOT_W-1:0] d_quot_d  [ND];
  logic              d_rdy     [ND];

  assign busy_o = clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(NUM_BINS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Ready runs back from the output.
  always_comb begin
    for (int k = ND - 1; k >= 0; k--) begin
      if (k == ND - 1) begin
        d_rdy[k] = !d_v_q[k] || out_ready_i;
      end else begin
        d_rdy[k] = !d_v_q[k] || d_rdy[k+1];
      end
    end
  end

  assign g3_rdy     = !g3_v_q || d_rdy[0];
  assign g2_rdy     = !g2_v_q || g3_rdy;
  assign g1_rdy     = !g1_v_q || g2_rdy;
  assign in_ready_o = g1_rdy;
  assign ld_g1      = g1_rdy && in_valid_i;

  // Profile entry of the bin: the index folded into the profile depth.
  always_comb begin
    slot_r = in_data_i.bin.bin_index;
    for (int k = 5; k >= 0; k--) begin
      if ((NUM_BINS << k) <= 511) begin
        if (slot_r >= IDX_W'(NUM_BINS << k)) begin
          slot_r = slot_r - IDX_W'(NUM_BINS << k);
        end
      end
    end
  end

  assign slot = AW'(slot_r);

  // A learn beat writes its magnitude; any other beat reads the entry.
  assign ram_we    = clr_busy_q || (ld_g1 && in_data_i.bin.action);
  assign ram_waddr = clr_busy_q ? clr_addr_q : slot;
  assign ram_wdata = clr_busy_q ? '0 : in_data_i.mag;

  ssbg_ram #(
    .WIDTH(ROOT_W),
    .DEPTH(NUM_BINS)
  ) u_profile (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ld_g1 && !in_data_i.bin.action),
    .raddr_i(slot),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learned_q <= 1'b0;
    end else if (ld_g1 && in_data_i.bin.action) begin
      learned_q <= 1'b1;
    end
  end

  // Numerator 3 * reduction * profile and denominator 1000 * magnitude.
  assign prof  = g1_bin_q.action ? g1_mag_q : ram_rdata;
  assign red3  = RED3_W'(cfg_i.reduction) * RED3_W'(OVER_SUB);
  assign num_d = {{SAMPLE_BITS{1'b0}}, red3} * {{RED3_W{1'b0}}, prof};
  assign den_d = {{(DEN_W - ROOT_W){1'b0}}, g1_mag_q} * DEN_W'(RED_FULL);

  // Divider stages, four quotient bits each.
  always_comb begin
    div_t              st;
    logic [DEN_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [QUOT_W-1:0] quot;
    for (int k = 0; k < ND; k++) begin
      if (k == 0) begin
        rem  = g3_rem_q;
        den  = g3_den_q;
        quot = '0;
      end else begin
        rem  = d_rem_q[k-1];
        den  = d_den_q[k-1];
        quot = d_quot_q[k-1];
      end
      for (int i = 0; i < DIV_ITERS; i++) begin
        st   = div_step(rem, den);
        rem  = st.rem;
        quot = {quot[QUOT_W-2:0], st.qbit};
      end
      d_rem_d[k]  = rem;
      d_quot_d[k] = quot;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_v_q <= 1'b0;
      g2_v_q <= 1'b0;
      g3_v_q <= 1'b0;
      for (int k = 0; k < ND; k++) begin
        d_v_q[k] <= 1'b0;
      end
    end else begin
      if (g1_rdy) begin
        g1_v_q <= in_valid_i;
      end
      if (g2_rdy) begin
        g2_v_q <= g1_v_q;
      end
      if (g3_rdy) begin
        g3_v_q <= g2_v_q;
      end
      for (int k = 0; k < ND; k++) begin
        if (d_rdy[k]) begin
          d_v_q[k] <= (k == 0) ? g3_v_q : d_v_q[k-1];
        end
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (g1_rdy) begin
      g1_bin_q <= in_data_i.bin;
      g1_mag_q <= in_data_i.mag;
      g1_lrn_q <= learned_q || in_data_i.bin.action;
    end
    if (g2_rdy) begin
      g2_bin_q  <= g1_bin_q;
      g2_num_q  <= num_d;
      g2_den_q  <= den_d;
      g2_pass_q <= !(g1_lrn_q && (cfg_i.reduction != '0));
      g2_magz_q <= (g1_mag_q == '0);
    end
    if (g3_rdy) begin
      g3_bin_q   <= g2_bin_q;
      g3_den_q   <= g2_den_q;
      g3_rem_q   <= g2_num_q[DEN_W-1:0];
      g3_clamp_q <= (g2_num_q >= NUM_W'(g2_den_q));
      g3_pass_q  <= g2_pass_q;
      g3_magz_q  <= g2_magz_q;
    end
    for (int k = 0; k < ND; k++) begin
      if (d_rdy[k]) begin
        d_bin_q[k]   <= (k == 0) ? g3_bin_q : d_bin_q[k-1];
        d_den_q[k]   <= (k == 0) ? g3_den_q : d_den_q[k-1];
        d_pass_q[k]  <= (k == 0) ? g3_pass_q : d_pass_q[k-1];
        d_magz_q[k]  <= (k == 0) ? g3_magz_q : d_magz_q[k-1];
        d_clamp_q[k] <= (k == 0) ? g3_clamp_q : d_clamp_q[k-1];
        d_rem_q[k]   <= d_rem_d[k];
        d_quot_q[k]  <= d_quot_d[k];
      end
    end
  end

  assign out_valid_o          = d_v_q[ND-1];
  assign out_data_o.bin_index = d_bin_q[ND-1].bin_index;
  assign out_data_o.bin_real  = d_bin_q[ND-1].bin_real;
  assign out_data_o.bin_imag  = d_bin_q[ND-1].bin_imag;
  assign out_data_o.pass      = d_pass_q[ND-1];
  assign out_data_o.mag_zero  = d_magz_q[ND-1];
  assign out_data_o.clamp     = d_clamp_q[ND-1];
  assign out_data_o.quot      = d_quot_q[ND-1];

endmodule

// ----- design/ssbg_scale.sv -----
module ssbg_scale import ssbg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  gain_beat_t in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_beat_t  out_data_o
);

  logic                     s1_v_q, s2_v_q, s1_rdy, s2_rdy;
  logic [IDX_W-1:0]         s1_idx_q;
  logic signed [PROD_W-1:0] s1_pr_q, s1_pi_q, pr_d, pi_d;
  out_beat_t                s2_q;
  logic [GAIN_W-1:0]        gain, fac;

  assign s2_rdy     = !s2_v_q || out_ready_i;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_ready_o = s1_rdy;

  // Gain from the quotient, floored, and the factor actually applied.
  always_comb begin
    gain = GAIN_ONE;
    if (!in_data_i.mag_zero) begin
      if (in_data_i.clamp || (in_data_i.quot >= QUOT_W'(GAIN_ONE - GAIN_FLOOR))) begin
        gain = GAIN_FLOOR;
      end else begin
        gain = GAIN_ONE - {1'b0, in_data_i.quot};
      end
    end
    if (in_data_i.pass) begin
      fac = GAIN_ONE;
    end else if (cfg_i.diff_mode) begin
      fac = GAIN_ONE - gain;
    end else begin
      fac = gain;
    end
  end

  assign pr_d = in_data_i.bin_real * $signed({1'b0, fac});
  assign pi_d = in_data_i.bin_imag * $signed({1'b0, fac});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  // Products, then rounding to the nearest with ties upwards.
  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_idx_q <= in_data_i.bin_index;
      s1_pr_q  <= pr_d;
      s1_pi_q  <= pi_d;
    end
    if (s2_rdy) begin
      s2_q.out_index <= s1_idx_q;
      s2_q.out_real  <= SAMPLE_BITS'((s1_pr_q + PROD_W'(32768)) >>> 16);
      s2_q.out_imag  <= SAMPLE_BITS'((s1_pi_q + PROD_W'(32768)) >>> 16);
    end
  end

  assign out_valid_o = s2_v_q;
  assign out_data_o  = s2_q;

endmodule

// ----- design/spectral_subtraction_bin_gain.sv -----
// Spectral subtraction gain for one FFT bin per beat. Each input beat carries a
// complex bin; the block forms its magnitude, optionally learns it into the
// per-bin noise profile, and scales the bin by the resulting gain (or by one
// minus the gain in difference mode). One bin is accepted every cycle while the
// output does not stall and the profile is not being cleared. A bin passes 8
// stages for squaring and the pipelined square root, 7 for the profile lookup and
// the pipelined divider, and 2 for scaling. After reset the profile memory is
// cleared, one entry a cycle, during which no input beat is taken;
// configuration writes are taken at all times and should be made while idle.
module spectral_subtraction_bin_gain import ssbg_pkg::*; #(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_beat_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t       cfg;
  logic [RED_W-1:0] red_q;
  logic       diff_q;
  logic       busy, mag_in_ready;
  logic       mag_valid, mag_ready, gain_valid, gain_ready;
  mag_beat_t  mag_beat;
  gain_beat_t gain_beat;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q  <= RED_RESET;
      diff_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_REDUCTION: red_q  <= cfg_data_i[RED_W-1:0];
        REG_DIFF_MODE: diff_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg.reduction = red_q;
  assign cfg.diff_mode = diff_q;

  // No input beat is taken while the profile is being cleared.
  assign in_ready_o = mag_in_ready && !busy;

  ssbg_mag u_mag (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i && !busy),
    .in_ready_o (mag_in_ready),
    .in_data_i  (in_data_i),
    .out_valid_o(mag_valid),
    .out_ready_i(mag_ready),
    .out_data_o (mag_beat)
  );

  ssbg_gain #(
    .NUM_BINS(NUM_BINS)
  ) u_gain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .busy_o     (busy),
    .in_valid_i (mag_valid),
    .in_ready_o (mag_ready),
    .in_data_i  (mag_beat),
    .out_valid_o(gain_valid),
    .out_ready_i(gain_ready),
    .out_data_o (gain_beat)
  );

  ssbg_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (gain_valid),
    .in_ready_o (gain_ready),
    .in_data_i  (gain_beat),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ----- verif/spectral_subtraction_bin_gain_tb.sv -----
`timescale 1ns / 1ps

module spectral_subtraction_bin_gain_tb;
  import ssbg_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_beat_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_beat_t             out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  spectral_subtraction_bin_gain dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  localparam int NBINS       = NUM_BINS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;

  // Shadow copy of the block's state and configuration.
  logic [SAMPLE_BITS-1:0] noise_shadow [NBINS];
  logic                   learned_shadow;
  logic [RED_W-1:0]       red_shadow;
  logic                   diff_shadow;

  in_beat_t  bins_pending [$];
  out_beat_t bins_expected [$];
  int        errors;
  int        cycle_count;
  int        accepted;
  int        stall_hold;

  // Integer square root, rounded down.
  function automatic longint unsigned mag_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Rounded product of a sample with a Q1.16 factor.
  function automatic logic [SAMPLE_BITS-1:0] apply_gain(input logic signed [SAMPLE_BITS-1:0] x,
                                                        input longint f);
    longint p;
    p = longint'(x) * f + 32768;
    return SAMPLE_BITS'(p >>> 16);
  endfunction

  // Works out the cleaned bin and updates the profile on learn beats.
  function automatic out_beat_t clean_bin(input in_beat_t b);
    out_beat_t       o;
    longint          re;
    longint          im;
    longint unsigned mag;
    longint unsigned num;
    longint unsigned den;
    longint unsigned sub;
    longint          g;
    longint          f;
    int              slot;
    re   = longint'(b.bin_real);
    im   = longint'(b.bin_imag);
    mag  = mag_root(longint'(re * re) + longint'(im * im));
    slot = int'(b.bin_index) % NBINS;
    o.out_index = b.bin_index;
    if (b.action) begin
      noise_shadow[slot] = SAMPLE_BITS'(mag);
      learned_shadow     = 1'b1;
    end
    if (learned_shadow && red_shadow != 0) begin
      g = 65536;
      if (mag != 0) begin
        num = 64'(3) * red_shadow * noise_shadow[slot] * 64'd65536;
        den = 64'd1000 * mag;
        sub = num / den;
        if (sub >= 65536 - 1311) g = 1311;
        else g = 65536 - longint'(sub);
      end
      f = diff_shadow ? 65536 - g : g;
      o.out_real = apply_gain(b.bin_real, f);
      o.out_imag = apply_gain(b.bin_imag, f);
    end else begin
      o.out_real = b.bin_real;
      o.out_imag = b.bin_imag;
    end
    return o;
  endfunction

  function automatic in_beat_t rand_bin(input logic act, input int amp);
    in_beat_t b;
    b.action    = act;
    b.bin_index = IDX_W'($urandom_range(NBINS - 1));
    case ($urandom_range(3))
      0: begin
        b.bin_real = SAMPLE_BITS'($urandom);
        b.bin_imag = SAMPLE_BITS'($urandom);
      end
      default: begin
        b.bin_real = SAMPLE_BITS'($signed($urandom_range(2 * amp)) - amp);
        b.bin_imag = SAMPLE_BITS'($signed($urandom_range(2 * amp)) - amp);
      end
    endcase
    return b;
  endfunction

  // Clock: low then high, 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Sender: bursts of random length separated by random gaps.
  int burst_left;
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        bins_expected.push_back(clean_bin(in_data_i));
        accepted = accepted + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (bins_pending.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= bins_pending.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(40, 1);
            gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold  <= stall_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      case ((cycle_count / 300) % 3)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(3) != 0);
        default: out_ready_i <= ($urandom_range(1) == 0);
      endcase
    end
  end

  // Monitor: compare each output beat with the oldest expectation.
  always @(posedge clk_i) begin
    out_beat_t exp_b;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (bins_expected.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, out_data_o);
        errors = errors + 1;
      end else begin
        exp_b = bins_expected.pop_front();
        if (out_data_o.out_index !== exp_b.out_index) begin
          $display("%0t: out_index expected %0d actual %0d", $time,
                   exp_b.out_index, out_data_o.out_index);
          errors = errors + 1;
        end
        if (out_data_o.out_real !== exp_b.out_real) begin
          $display("%0t: out_real expected %0d actual %0d", $time,
                   exp_b.out_real, out_data_o.out_real);
          errors = errors + 1;
        end
        if (out_data_o.out_imag !== exp_b.out_imag) begin
          $display("%0t: out_imag expected %0d actual %0d", $time,
                   exp_b.out_imag, out_data_o.out_imag);
          errors = errors + 1;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL spectral_subtraction_bin_gain");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_REDUCTION) red_shadow = val;
    else diff_shadow = val[0];
  endtask

  // Waits until every queued bin has been sent and checked.
  task automatic drain();
    while (bins_pending.size() > 0 || in_valid_i || bins_expected.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic push_bin(input logic act, input int idx, input int re, input int im);
    in_beat_t b;
    b.action    = act;
    b.bin_index = IDX_W'(idx);
    b.bin_real  = SAMPLE_BITS'(re);
    b.bin_imag  = SAMPLE_BITS'(im);
    bins_pending.push_back(b);
  endtask

  initial begin
    logic [RED_W-1:0] red_set [6];
    int               amp;
    errors         = 0;
    cycle_count    = 0;
    accepted       = 0;
    stall_hold     = 0;
    learned_shadow = 1'b0;
    red_shadow     = RED_RESET;
    diff_shadow    = 1'b0;
    foreach (noise_shadow[i]) noise_shadow[i] = '0;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    red_set     = '{10'd1000, 10'd0, 10'd1023, 10'd1, 10'd250, 10'd700};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: pass-through before any learning, then extremes and zeros.
    push_bin(1'b0, 3, 8388607, -8388608);
    push_bin(1'b0, 511, -1, 1);
    push_bin(1'b1, 5, 1000, 0);
    push_bin(1'b0, 5, 3000, 4000);
    push_bin(1'b0, 5, 1000, 0);
    push_bin(1'b0, 5, 0, 0);
    push_bin(1'b1, 7, 0, 0);
    push_bin(1'b0, 7, 500, -500);
    push_bin(1'b1, 511, -8388608, -8388608);
    push_bin(1'b0, 511, 8388607, 8388607);
    push_bin(1'b0, 511, -8388608, 8388607);
    push_bin(1'b1, 0, 8388607, 0);
    push_bin(1'b0, 0, 1, -1);
    drain();
    write_reg(REG_DIFF_MODE, 1'b1);
    push_bin(1'b0, 5, 3000, 4000);
    push_bin(1'b0, 5, 0, 0);
    push_bin(1'b0, 0, -8388608, 8388607);
    push_bin(1'b1, 9, 123456, -654321);
    push_bin(1'b0, 9, 123456, -654321);
    drain();

    // Random phases over several settings; long receiver hold-off in one.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_REDUCTION, red_set[ph]);
      write_reg(REG_DIFF_MODE, ph[0]);
      amp = (ph % 2) ? 8388607 : 20000;
      for (int n = 0; n < 215; n++)
        bins_pending.push_back(rand_bin($urandom_range(4) == 0, amp));
      if (ph == 2) begin
        repeat (50) @(posedge clk_i);
        stall_hold = 200;
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS spectral_subtraction_bin_gain");
    end else begin
      $display("FAIL spectral_subtraction_bin_gain");
    end
    $finish;
  end

endmodule
